@@ sv/lrupr_pkg.sv @@
// package for the lru page replacement block: sizes, controller states and the
// command bundle from controller to datapath. no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lrupr_pkg;

  localparam int FRAMES     = 4;
  localparam int PAGE_BITS  = 16;
  localparam int PAGE_W     = 16;
  localparam int FRAME_BITS = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int RANK_BITS  = FRAME_BITS;
  localparam int INDEX_W    = 2;
  localparam int COUNT_W    = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } lrupr_state_t;

  typedef struct packed {
    logic load;   // capture the incoming page reference
    logic exec;   // look up the frames and commit the update
  } lrupr_cmd_t;

endpackage

`default_nettype wire

@@ sv/lru_page_replacement.sv @@
// top level of the lru page replacement block: controller plus datapath.
// uses lrupr_pkg, lrupr_ctrl and lrupr_dpath
//
//   channel  | ports                                              | handshake
//   ---------+----------------------------------------------------+-------------------
//   request  | page                                               | start, busy
//   result   | hit, frame_index, evicted_valid, evicted_page,     | done (one cycle)
//            | hit_total                                          |
//
// a beat is accepted when start is high and busy is low; its page is registered,
// then ST_EXEC does the parallel frame compare and rank update and registers the
// result, and done strobes in ST_RESP. a new beat may be taken while done is up,
// so the sustained rate is one beat every two cycles. synchronous reset empties
// all frames and clears the hit count. the receiver cannot stall the result.
`timescale 1ns / 1ps
`default_nettype none

module lru_page_replacement (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [lrupr_pkg::PAGE_W-1:0]  page,
  output logic                               done,
  output logic                               hit,
  output logic [lrupr_pkg::INDEX_W-1:0]      frame_index,
  output logic                               evicted_valid,
  output logic [lrupr_pkg::PAGE_W-1:0]       evicted_page,
  output logic [lrupr_pkg::COUNT_W-1:0]      hit_total
);

  lrupr_pkg::lrupr_cmd_t cmd;

  lrupr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  lrupr_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .page          (page),
    .hit           (hit),
    .frame_index   (frame_index),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .hit_total     (hit_total)
  );

endmodule

`default_nettype wire

@@ sv/lrupr_ctrl.sv @@
// controller for the lru page replacement block: accepts a beat, runs the
// lookup in ST_EXEC and raises the result strobe in ST_RESP. uses lrupr_pkg
`timescale 1ns / 1ps
`default_nettype none

module lrupr_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output lrupr_pkg::lrupr_cmd_t   cmd,
  output logic                    busy,
  output logic                    done
);

  lrupr_pkg::lrupr_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrupr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lrupr_pkg::ST_IDLE: begin
        if (start) state_next = lrupr_pkg::ST_EXEC;
      end
      lrupr_pkg::ST_EXEC: begin
        state_next = lrupr_pkg::ST_RESP;
      end
      lrupr_pkg::ST_RESP: begin
        state_next = start ? lrupr_pkg::ST_EXEC : lrupr_pkg::ST_IDLE;
      end
      default: begin
        state_next = lrupr_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy     = (state == lrupr_pkg::ST_EXEC);
    done     = (state == lrupr_pkg::ST_RESP);
    cmd.exec = (state == lrupr_pkg::ST_EXEC);
    cmd.load = start && !busy;
  end

endmodule

`default_nettype wire

@@ sv/lrupr_dpath.sv @@
// datapath for the lru page replacement block: frame table, recency ranks,
// hit counter and result registers. uses lrupr_pkg
`timescale 1ns / 1ps
`default_nettype none

module lrupr_dpath (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire lrupr_pkg::lrupr_cmd_t             cmd,
  input  wire logic [lrupr_pkg::PAGE_W-1:0]      page,
  output logic                                   hit,
  output logic [lrupr_pkg::INDEX_W-1:0]          frame_index,
  output logic                                   evicted_valid,
  output logic [lrupr_pkg::PAGE_W-1:0]           evicted_page,
  output logic [lrupr_pkg::COUNT_W-1:0]          hit_total
);

  logic [lrupr_pkg::PAGE_BITS-1:0]  page_reg;
  logic [lrupr_pkg::PAGE_BITS-1:0]  frame_page [lrupr_pkg::FRAMES];
  logic [lrupr_pkg::FRAMES-1:0]     frame_valid;
  logic [lrupr_pkg::RANK_BITS-1:0]  rank [lrupr_pkg::FRAMES];
  logic [lrupr_pkg::COUNT_W-1:0]    hit_count;

  logic                             res_hit;
  logic [lrupr_pkg::INDEX_W-1:0]    res_index;
  logic                             res_evicted_valid;
  logic [lrupr_pkg::PAGE_W-1:0]     res_evicted_page;

  logic                             lk_hit;
  logic                             lk_fill;
  logic                             lk_evict;
  logic [lrupr_pkg::FRAME_BITS-1:0] hit_slot;
  logic [lrupr_pkg::FRAME_BITS-1:0] empty_slot;
  logic [lrupr_pkg::FRAME_BITS-1:0] victim_slot;
  logic [lrupr_pkg::FRAME_BITS-1:0] slot;
  logic [lrupr_pkg::RANK_BITS-1:0]  best_rank;
  logic [lrupr_pkg::RANK_BITS-1:0]  old_rank;
  logic [lrupr_pkg::FRAMES-1:0]     match;
  logic [lrupr_pkg::FRAMES-1:0]     age;

  // parallel compare against every valid frame
  always_comb begin
    for (int i = 0; i < lrupr_pkg::FRAMES; i++) begin
      match[i] = frame_valid[i] && (frame_page[i] == page_reg);
    end
  end

  // lowest-numbered hit and lowest-numbered empty frame
  always_comb begin
    hit_slot   = '0;
    empty_slot = '0;
    for (int i = lrupr_pkg::FRAMES - 1; i >= 0; i--) begin
      if (match[i]) hit_slot = lrupr_pkg::FRAME_BITS'(i);
      if (!frame_valid[i]) empty_slot = lrupr_pkg::FRAME_BITS'(i);
    end
    lk_hit   = |match;
    lk_fill  = !lk_hit && !(&frame_valid);
    lk_evict = !lk_hit && (&frame_valid);
  end

  // oldest frame, lowest index on a tie
  always_comb begin
    victim_slot = '0;
    best_rank   = '0;
    for (int i = 0; i < lrupr_pkg::FRAMES; i++) begin
      if (rank[i] > best_rank) begin
        best_rank   = rank[i];
        victim_slot = lrupr_pkg::FRAME_BITS'(i);
      end
    end
  end

  always_comb begin
    priority if (lk_hit) begin
      slot = hit_slot;
    end else if (lk_fill) begin
      slot = empty_slot;
    end else begin
      slot = victim_slot;
    end
    old_rank = rank[slot];
    // a fill ages every valid frame, a touch only those younger than the slot
    for (int i = 0; i < lrupr_pkg::FRAMES; i++) begin
      age[i] = frame_valid[i] && (lrupr_pkg::FRAME_BITS'(i) != slot)
               && (lk_fill || (rank[i] < old_rank));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page_reg <= page[lrupr_pkg::PAGE_BITS-1:0];
    end
    if (cmd.exec && !lk_hit) begin
      frame_page[slot] <= page_reg;
    end
    if (cmd.exec) begin
      res_hit           <= lk_hit;
      res_index         <= lrupr_pkg::INDEX_W'(slot);
      res_evicted_valid <= lk_evict;
      res_evicted_page  <= lk_evict ? lrupr_pkg::PAGE_W'(frame_page[slot]) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= '0;
      hit_count   <= '0;
      for (int i = 0; i < lrupr_pkg::FRAMES; i++) begin
        rank[i] <= '0;
      end
    end else if (cmd.exec) begin
      frame_valid[slot] <= 1'b1;
      for (int i = 0; i < lrupr_pkg::FRAMES; i++) begin
        if (lrupr_pkg::FRAME_BITS'(i) == slot) begin
          rank[i] <= '0;
        end else if (age[i]) begin
          rank[i] <= rank[i] + 1'b1;
        end
      end
      if (lk_hit && (hit_count != '1)) begin
        hit_count <= hit_count + 1'b1;
      end
    end
  end

  assign hit           = res_hit;
  assign frame_index   = res_index;
  assign evicted_valid = res_evicted_valid;
  assign evicted_page  = res_evicted_page;
  assign hit_total     = hit_count;

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> !(res_hit && res_evicted_valid))
    else $error("hit reported together with an eviction");

  a_evict_only_full: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> (res_evicted_valid == ($past(&frame_valid) && !res_hit)))
    else $error("eviction without a full frame table");

  a_valid_sticky: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ((frame_valid & $past(frame_valid)) == $past(frame_valid)))
    else $error("a filled frame went empty");

  a_count_mono: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (hit_count >= $past(hit_count)))
    else $error("hit counter went backwards");

endmodule

`default_nettype wire
